>>> hw/rtl/lcwu_pkg.sv
// Shared types and constants for the LRU cache with word usage tracking.
package lcwu_pkg;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_INVAL = 2'd2;
    localparam logic [1:0] FUNC_MARK  = 2'd3;

    localparam logic [1:0] CFG_LSL  = 2'd0;
    localparam logic [1:0] CFG_SIB  = 2'd1;
    localparam logic [1:0] CFG_WAYS = 2'd2;

    localparam int BLOCK_W = 30;
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [6:0]  access_size;
        logic [29:0] evict_block;
    } t_in_word;

    typedef struct packed {
        logic        miss;
        logic        error;
        logic        first_evicted_valid;
        logic [29:0] first_evicted_block;
        logic        first_evicted_dirty;
        logic        second_evicted_valid;
        logic [29:0] second_evicted_block;
        logic        second_evicted_dirty;
        logic [31:0] used_words_total;
    } t_out_word;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture input word and precompute lines
        logic rd;        // issue set read for current line
        logic upd;       // compute and write set for current line
        logic second;    // current line is the second one
        logic finish;    // publish result
    } t_cmd;

    typedef struct packed {
        logic error;     // access too wide or past address end
        logic two;       // access touches two lines
    } t_sts;

endpackage

>>> hw/rtl/lru_cache_with_word_usage.sv
// Top level of the LRU write-allocate cache with word usage counting.
// Each word is accepted, then each touched line (one or two) passes through load,
// set read and set update, then the result is published; an access rejected as
// too wide goes from load straight to the result. The set store is one RAM row per
// set holding all ways; each line is a read then a read-modify-write of that row.
// A new word is taken once the previous result has been handed to the output
// register; a stalled output holds the block in its result state.
module lru_cache_with_word_usage #(
    parameter int SETS           = 64,
    parameter int WAYS           = 8,
    parameter int MAX_LINE_BYTES = 64,
    parameter int ADDR_BITS      = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [3:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lcwu_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lcwu_pkg::t_out_word o_out_word
);
    lcwu_pkg::t_cmd cmd;
    lcwu_pkg::t_sts sts;

    lcwu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lcwu_dp #(
        .SETS(SETS), .WAYS(WAYS), .MAX_LINE_BYTES(MAX_LINE_BYTES), .ADDR_BITS(ADDR_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_word     (i_in_word),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_word     (o_out_word)
    );
endmodule

>>> hw/rtl/lcwu_ram.sv
// Generic RAM with separate write and read ports and registered read.
module lcwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/lcwu_ctrl.sv
// Sequencer: load, then read and update one set per touched line.
module lcwu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  lcwu_pkg::t_sts  i_sts,
    output lcwu_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_second, n_second;
    logic       r_ovalid, n_ovalid;
    logic       accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd    = '0;
        o_cmd.second = r_second;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                    n_second   = 1'b0;
                end
            end
            S_LOAD: begin
                if (i_sts.error) n_state = S_DONE;
                else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_RD: n_state = S_UPD;
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_sts.two && !r_second) begin
                    n_second = 1'b1;
                    n_state  = S_LOAD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.load, o_cmd.rd, o_cmd.upd, o_cmd.finish}) <= 1)
        else $error("multiple commands");
    a_rd_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> ##1 o_cmd.upd)
        else $error("update does not follow read");
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_out_valid)
        else $error("result not shown");
`endif
endmodule

>>> hw/rtl/lcwu_dp.sv
// Datapath: line split, set store, LRU update, word mask and total.
module lcwu_dp #(
    parameter int SETS           = 64,
    parameter int WAYS           = 8,
    parameter int MAX_LINE_BYTES = 64,
    parameter int ADDR_BITS      = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [3:0]          i_cfg_data,
    input  lcwu_pkg::t_in_word  i_word,
    input  lcwu_pkg::t_cmd      i_cmd,
    output lcwu_pkg::t_sts      o_sts,
    output lcwu_pkg::t_out_word o_word
);
    localparam int SB    = (SETS > 1) ? $clog2(SETS) : 1;
    // floor of log2: largest set index width and line size in use
    localparam int SMAX  = $clog2(SETS + 1) - 1;
    localparam int LMAX  = $clog2(MAX_LINE_BYTES + 1) - 1;
    localparam int WPL   = MAX_LINE_BYTES / 4;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT  = $clog2(WAYS + 1);
    localparam int PCW   = $clog2(WPL + 1);
    localparam int LW    = lcwu_pkg::BLOCK_W + WPL + 2;
    localparam int SETW  = LW * WAYS;
    localparam int BW    = lcwu_pkg::BLOCK_W;

    typedef struct packed {
        logic [BW-1:0]  tag;
        logic [WPL-1:0] words;
        logic           valid;
        logic           dirty;
    } t_line;

    // configuration
    logic [2:0] r_lsl, r_sib;
    logic [3:0] r_ways;
    logic [2:0] eff_lsl;
    logic [2:0] eff_sib;
    logic [WCNT-1:0] eff_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsl  <= 3'd6;
            r_sib  <= 3'd6;
            r_ways <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lcwu_pkg::CFG_LSL:  r_lsl  <= i_cfg_data[2:0];
                lcwu_pkg::CFG_SIB:  r_sib  <= i_cfg_data[2:0];
                lcwu_pkg::CFG_WAYS: r_ways <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_lsl = r_lsl;
        if (r_lsl < 3'd2) eff_lsl = 3'd2;
        if (32'(r_lsl) > LMAX) eff_lsl = 3'(LMAX);
        eff_sib = (32'(r_sib) > SMAX) ? 3'(SMAX) : r_sib;
        if (r_ways == 4'd0) eff_ways = WCNT'(1);
        else if (32'(r_ways) > WAYS) eff_ways = WCNT'(WAYS);
        else eff_ways = WCNT'(r_ways);
    end

    // captured input
    logic [1:0]           r_func;
    logic [ADDR_BITS-1:0] r_addr;
    logic [6:0]           r_size;
    logic [BW-1:0]        r_eblk;
    logic                 r_err, r_two;
    logic [BW-1:0]        r_b1, r_b2;
    logic [WPL-1:0]       r_m1, r_m2;

    logic [ADDR_BITS:0]   end_full;
    logic [ADDR_BITS-1:0] end_a;
    logic [ADDR_BITS-1:0] b1_full, b2_full;
    logic [7:0]           lmask;
    logic [5:0]           fw, lw, lastw;
    logic [6:0]           sz;

    // first part of the precompute: combinational on the registered addr, used in S_LOAD
    always_comb begin
        sz       = (r_size == 7'd0) ? 7'd1 : r_size;
        end_full = {1'b0, r_addr} + (ADDR_BITS+1)'(sz) - (ADDR_BITS+1)'(1);
        end_a    = end_full[ADDR_BITS-1:0];
        b1_full  = r_addr >> eff_lsl;
        b2_full  = end_a >> eff_lsl;
        lmask    = 8'((9'd1 << eff_lsl) - 9'd1);
        fw       = 6'((8'(r_addr[7:0]) & lmask) >> 2);
        lw       = 6'((8'(end_a[7:0]) & lmask) >> 2);
        lastw    = 6'(lmask >> 2);
    end

    function automatic logic [WPL-1:0] wrange(input logic [5:0] f, input logic [5:0] l);
        logic [WPL-1:0] m;
        for (int k = 0; k < WPL; k++) m[k] = (6'(k) >= f) && (6'(k) <= l);
        return m;
    endfunction

    logic r_calc;   // set after a load: precompute results are live, not yet registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_word.func;
            r_addr <= ADDR_BITS'(i_word.address);
            r_size <= i_word.access_size;
            r_eblk <= i_word.evict_block;
        end
        if (!i_rst_n) r_calc <= 1'b0;
        else r_calc <= i_cmd.load;
        if (r_calc) begin
            r_err <= (r_func != lcwu_pkg::FUNC_INVAL) &&
                     (end_full[ADDR_BITS] ||
                      (b1_full != b2_full && b1_full + ADDR_BITS'(1) != b2_full));
            r_two <= (r_func != lcwu_pkg::FUNC_INVAL) && (b1_full != b2_full);
            r_b1  <= (r_func == lcwu_pkg::FUNC_INVAL) ? r_eblk : BW'(b1_full);
            r_b2  <= BW'(b2_full);
            r_m1  <= (b1_full == b2_full) ? wrange(fw, lw) : wrange(fw, lastw);
            r_m2  <= wrange(6'd0, lw);
        end
    end

    // combinational status for S_LOAD (first pass) uses live values
    logic err_now, two_now;
    assign err_now = r_calc ? ((r_func != lcwu_pkg::FUNC_INVAL) &&
                     (end_full[ADDR_BITS] ||
                      (b1_full != b2_full && b1_full + ADDR_BITS'(1) != b2_full))) : r_err;
    assign two_now = r_calc ? ((r_func != lcwu_pkg::FUNC_INVAL) && (b1_full != b2_full))
                            : r_two;
    assign o_sts.error = err_now;
    assign o_sts.two   = two_now;

    // set store
    logic [BW-1:0]   cur_blk;
    logic [WPL-1:0]  cur_m;
    logic [SB-1:0]   set_idx;
    logic [SETW-1:0] rdata, wdata;
    logic            we;
    logic [SETS-1:0] r_sv;   // set has been written since reset

    assign cur_blk = i_cmd.second ? r_b2 : (r_calc ? ((r_func == lcwu_pkg::FUNC_INVAL)
                     ? r_eblk : BW'(b1_full)) : r_b1);
    assign cur_m   = i_cmd.second ? r_m2 : r_m1;

    logic [BW-1:0] r_cur_blk;
    logic [SB-1:0] r_set_idx;
    always_comb begin
        set_idx = '0;
        for (int k = 0; k < SB; k++)
            if (k < 32'(eff_sib)) set_idx[k] = cur_blk[k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_cur_blk <= cur_blk;
            r_set_idx <= set_idx;
        end
    end

    lcwu_ram #(.WIDTH(SETW), .DEPTH(SETS)) u_sets (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_set_idx),
        .i_wdata (wdata),
        .i_raddr (set_idx),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= '0;
        else if (we) r_sv[r_set_idx] <= 1'b1;
    end

    // update of one set
    t_line lines [WAYS];
    t_line nl    [WAYS];
    logic [WAYS-1:0] hitv;
    logic            hit;
    logic [WW-1:0]   hw;
    t_line           rec, vic;
    logic [PCW-1:0]  pc_old, pc_new;
    logic            ev_v, ev_d;
    logic [BW-1:0]   ev_b;
    logic            write;
    logic [WCNT-1:0] lastway;
    logic            do_add;

    assign write   = (r_func == lcwu_pkg::FUNC_WRITE);
    assign lastway = eff_ways - WCNT'(1);

    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            lines[k] = rdata[k*LW +: LW];
            if (!r_sv[r_set_idx]) lines[k].valid = 1'b0;
            if (!lines[k].valid) begin
                lines[k].dirty = 1'b0;
                lines[k].words = '0;
            end
            hitv[k] = (k < 32'(eff_ways)) && lines[k].valid && lines[k].tag == r_cur_blk;
        end
        hit = 1'b0;
        hw  = '0;
        for (int k = WAYS - 1; k >= 0; k--)
            if (hitv[k]) begin
                hit = 1'b1;
                hw  = WW'(k);
            end
        rec = lines[hw];
        vic = lines[lastway[WW-1:0]];
        ev_v = 1'b0; ev_b = '0; ev_d = 1'b0;
        pc_old = '0; pc_new = '0;
        do_add = 1'b0;
        for (int k = 0; k < WAYS; k++) nl[k] = lines[k];
        case (r_func)
            lcwu_pkg::FUNC_INVAL: begin
                if (hit) begin
                    ev_v = 1'b1; ev_b = rec.tag; ev_d = rec.dirty;
                    for (int k = 0; k < WAYS; k++) begin
                        if (k >= 32'(hw) && k + 1 < 32'(eff_ways)) nl[k] = lines[k+1];
                        if (k + 1 == 32'(eff_ways) && k >= 32'(hw)) nl[k] = '0;
                    end
                end
            end
            lcwu_pkg::FUNC_MARK: begin
                if (hit) nl[hw].dirty = 1'b1;
            end
            default: begin
                do_add = 1'b1;
                if (hit) begin
                    pc_old = PCW'($countones(rec.words));
                    pc_new = PCW'($countones(rec.words | cur_m));
                    rec.words = rec.words | cur_m;
                    if (write) rec.dirty = 1'b1;
                    for (int k = 1; k < WAYS; k++)
                        if (k <= 32'(hw)) nl[k] = lines[k-1];
                    nl[0] = rec;
                end else begin
                    ev_v = vic.valid;
                    ev_b = vic.valid ? vic.tag : '0;
                    ev_d = vic.valid && vic.dirty;
                    pc_new = PCW'($countones(cur_m));
                    for (int k = 1; k < WAYS; k++)
                        if (k < 32'(eff_ways)) nl[k] = lines[k-1];
                    nl[0].tag   = r_cur_blk;
                    nl[0].words = cur_m;
                    nl[0].valid = 1'b1;
                    nl[0].dirty = write;
                end
            end
        endcase
        for (int k = 0; k < WAYS; k++) wdata[k*LW +: LW] = nl[k];
    end

    assign we = i_cmd.upd;

    // word total and result
    logic [31:0] r_total;
    logic [32:0] sum;
    lcwu_pkg::t_out_word r_res, r_out, res_fin;
    assign sum = {1'b0, r_total} + 33'(pc_new - pc_old);

    always_comb begin
        res_fin = r_res;
        res_fin.error = err_now;
        res_fin.used_words_total = r_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_total <= '0;
        else if (i_cmd.upd && do_add) r_total <= sum[32] ? '1 : sum[31:0];
        if (i_cmd.load) r_res <= '0;
        else if (i_cmd.upd) begin
            if (do_add && !hit) r_res.miss <= 1'b1;
            if (i_cmd.second) begin
                r_res.second_evicted_valid <= ev_v;
                r_res.second_evicted_block <= ev_b;
                r_res.second_evicted_dirty <= ev_d;
            end else begin
                r_res.first_evicted_valid <= ev_v;
                r_res.first_evicted_block <= ev_b;
                r_res.first_evicted_dirty <= ev_d;
            end
        end
        if (i_cmd.finish) r_out <= res_fin;
    end
    assign o_word = r_out;

`ifndef SYNTHESIS
    a_ways_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eff_ways != '0 && 32'(eff_ways) <= WAYS)
        else $error("ways in use out of range");
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_total >= $past(r_total))
        else $error("word total decreased");
    a_err_noupd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd |-> !r_err)
        else $error("update on wide access");
`endif
endmodule
